// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HVD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HVD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hvd_pkg.sv =====
`timescale 1ns / 1ps

package hvd_pkg;

    // Angle in half-units of 5e-8 degree, two's complement
    localparam int unsigned ANG_W = 34;
    // CORDIC datapath width, signed
    localparam int unsigned CW = 36;
    localparam int unsigned SQ_STEPS = 32;
    localparam int unsigned CD_STEPS = 32;
    localparam int unsigned NSTEP = 6;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    // Full turn, quadrant and octant in half-units
    localparam logic [33:0] HALF_FULL = 34'd7200000000;
    localparam logic [32:0] HALF_Q1 = 33'd1800000000;
    localparam logic [32:0] HALF_Q2 = 33'd3600000000;
    localparam logic [32:0] HALF_Q3 = 33'd5400000000;
    localparam logic [30:0] HALF_OCT = 31'd900000000;

    // Half-units to radians Q32: integer and fraction parts of pi*2^60 / 3.6e9
    localparam logic [31:0] KHI = 32'(PI_Q60 / 64'd3600000000);
    localparam logic [31:0] KLO =
        32'(((PI_Q60 % 64'd3600000000) << 32) / 64'd3600000000);

    localparam logic [30:0] RADIUS_CM_RESET = 31'd637100000;

    // Horner divisors; sine runs one step fewer, so its first entry is skipped
    localparam logic [7:0] SIN_DIV [NSTEP] = '{8'd1, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [NSTEP] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // Shift-subtract quotient, evaluated at elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q32, rounded from the Q62 power series
    function automatic logic [31:0] atan_q32(input int unsigned i);
        logic [63:0] v;
        logic [63:0] term;
        logic [63:0] n;
        int e;
        v = '0;
        n = '0;
        if (i == 0)
        begin
            v = PI_Q60;
        end
        else
        begin
            e = 62 - int'(i);
            while (e >= 0)
            begin
                term = udiv64(64'd1 << e, 64'd2 * n + 64'd1);
                if (n[0])
                    v = v - term;
                else
                    v = v + term;
                e = e - 2 * int'(i);
                n = n + 64'd1;
            end
        end
        return 32'((v + (64'd1 << 29)) >> 30);
    endfunction

endpackage

// ===== hdl/hvd_sincos.sv =====
`timescale 1ns / 1ps

// Pipelined sine or cosine of an angle in half-units: octant fold, Taylor
// series by Horner steps. Gives the magnitude and, for cosine, the sign.
module hvd_sincos (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [hvd_pkg::ANG_W-1:0]   angle,
    input  logic                               want_cos,
    output logic                               out_valid,
    output logic [32:0]                        mag,
    output logic                               neg
);

    typedef struct packed {
        logic        pc;  // run the cosine series
        logic        ng;  // result negative unless zero
        logic [31:0] x;
        logic [31:0] x2;
    } side_t;

    // Stage 1: reduce into one turn
    logic        s1_v_reg;
    logic [32:0] s1_r_reg;
    logic        s1_wc_reg;
    logic [33:0] r_sum;

    assign r_sum = angle[hvd_pkg::ANG_W-1] ? 34'(angle) + hvd_pkg::HALF_FULL : 34'(angle);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg  <= r_sum[32:0];
            s1_wc_reg <= want_cos;
        end
    end

    // Stage 2: quadrant and remainder
    logic        s2_v_reg;
    logic [1:0]  s2_q_reg;
    logic [30:0] s2_rem_reg;
    logic        s2_wc_reg;
    logic [1:0]  q_next;
    logic [32:0] q_off;

    always_comb
    begin
        if (s1_r_reg >= hvd_pkg::HALF_Q3)
        begin
            q_next = 2'd3;
            q_off  = hvd_pkg::HALF_Q3;
        end
        else if (s1_r_reg >= hvd_pkg::HALF_Q2)
        begin
            q_next = 2'd2;
            q_off  = hvd_pkg::HALF_Q2;
        end
        else if (s1_r_reg >= hvd_pkg::HALF_Q1)
        begin
            q_next = 2'd1;
            q_off  = hvd_pkg::HALF_Q1;
        end
        else
        begin
            q_next = 2'd0;
            q_off  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_q_reg   <= q_next;
            s2_rem_reg <= 31'(s1_r_reg - q_off);
            s2_wc_reg  <= s1_wc_reg;
        end
    end

    // Stage 3: octant fold, pick series and sign
    logic        s3_v_reg;
    logic [29:0] s3_xr_reg;
    logic        s3_pc_reg;
    logic        s3_ng_reg;
    logic        low_oct;
    logic        oct_match;

    assign low_oct   = (s2_rem_reg <= hvd_pkg::HALF_OCT);
    assign oct_match = (!s2_q_reg[0]) == low_oct;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_xr_reg <= low_oct ? s2_rem_reg[29:0]
                                 : 30'(31'(hvd_pkg::HALF_Q1) - s2_rem_reg);
            s3_pc_reg <= !(s2_wc_reg ^ oct_match);
            s3_ng_reg <= s2_wc_reg && ((s2_q_reg == 2'd1) || (s2_q_reg == 2'd2));
        end
    end

    // Stage 4: radian conversion products
    logic        s4_v_reg;
    logic [61:0] s4_phi_reg;
    logic [61:0] s4_plo_reg;
    logic        s4_pc_reg;
    logic        s4_ng_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (en)
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_phi_reg <= 62'(s3_xr_reg) * 62'(hvd_pkg::KHI);
            s4_plo_reg <= 62'(s3_xr_reg) * 62'(hvd_pkg::KLO);
            s4_pc_reg  <= s3_pc_reg;
            s4_ng_reg  <= s3_ng_reg;
        end
    end

    // Stage 5: radians Q32
    logic        s5_v_reg;
    logic [31:0] s5_x_reg;
    logic        s5_pc_reg;
    logic        s5_ng_reg;
    logic [61:0] rad_sum;

    assign rad_sum = s4_phi_reg + (s4_plo_reg >> 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_v_reg <= 1'b0;
        else if (en)
            s5_v_reg <= s4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_x_reg  <= 32'(rad_sum >> 28);
            s5_pc_reg <= s4_pc_reg;
            s5_ng_reg <= s4_ng_reg;
        end
    end

    // Stage 6: x squared
    logic        s6_v_reg;
    side_t       s6_side_reg;
    logic [63:0] x_sq;

    assign x_sq = 64'(s5_x_reg) * 64'(s5_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_v_reg <= 1'b0;
        else if (en)
            s6_v_reg <= s5_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_side_reg.pc <= s5_pc_reg;
            s6_side_reg.ng <= s5_ng_reg;
            s6_side_reg.x  <= s5_x_reg;
            s6_side_reg.x2 <= x_sq[63:32];
        end
    end

    // Horner steps: multiply, reciprocal multiply, correct and subtract
    logic        a_v_reg    [hvd_pkg::NSTEP];
    logic [31:0] a_p_reg    [hvd_pkg::NSTEP];
    side_t       a_side_reg [hvd_pkg::NSTEP];
    logic        b_v_reg    [hvd_pkg::NSTEP];
    logic [31:0] b_p_reg    [hvd_pkg::NSTEP];
    logic [31:0] b_q_reg    [hvd_pkg::NSTEP];
    side_t       b_side_reg [hvd_pkg::NSTEP];
    logic        c_v_reg    [hvd_pkg::NSTEP];
    logic [32:0] c_t_reg    [hvd_pkg::NSTEP];
    side_t       c_side_reg [hvd_pkg::NSTEP];

    for (genvar k = 0; k < hvd_pkg::NSTEP; k++)
    begin : g_step
        localparam logic [7:0]  N_COS = hvd_pkg::COS_DIV[k];
        localparam logic [7:0]  N_SIN = hvd_pkg::SIN_DIV[k];
        localparam logic [32:0] M_COS = 33'((64'd1 << 32) / 64'(N_COS));
        localparam logic [32:0] M_SIN = 33'((64'd1 << 32) / 64'(N_SIN));
        localparam logic        FIRST = (k == 0);

        logic        v_in;
        logic [32:0] t_in;
        side_t       side_in;
        logic [64:0] a_prod;
        logic [64:0] b_prod;
        logic [7:0]  nn;
        logic [39:0] qn;
        logic [39:0] rem;
        logic [31:0] q_fix;
        logic        bypass;

        if (k == 0)
        begin : g_head
            assign v_in    = s6_v_reg;
            assign t_in    = hvd_pkg::ONE_Q32;
            assign side_in = s6_side_reg;
        end
        else
        begin : g_chain
            assign v_in    = c_v_reg[k-1];
            assign t_in    = c_t_reg[k-1];
            assign side_in = c_side_reg[k-1];
        end

        assign a_prod = 65'(side_in.x2) * 65'(t_in);
        assign b_prod = 65'(a_p_reg[k]) * 65'(a_side_reg[k].pc ? M_COS : M_SIN);
        assign nn     = b_side_reg[k].pc ? N_COS : N_SIN;
        assign qn     = 40'(b_q_reg[k]) * 40'(nn);
        assign rem    = 40'(b_p_reg[k]) - qn;
        assign q_fix  = b_q_reg[k] + 32'(rem >= 40'(nn));
        assign bypass = FIRST && !b_side_reg[k].pc;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_v_reg[k] <= 1'b0;
                b_v_reg[k] <= 1'b0;
                c_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                a_v_reg[k] <= v_in;
                b_v_reg[k] <= a_v_reg[k];
                c_v_reg[k] <= b_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_p_reg[k]    <= a_prod[63:32];
                a_side_reg[k] <= side_in;
                b_p_reg[k]    <= a_p_reg[k];
                b_q_reg[k]    <= b_prod[63:32];
                b_side_reg[k] <= a_side_reg[k];
                c_t_reg[k]    <= bypass ? hvd_pkg::ONE_Q32 : hvd_pkg::ONE_Q32 - 33'(q_fix);
                c_side_reg[k] <= b_side_reg[k];
            end
        end
    end

    // Final stage: sine takes one more product with x
    logic        out_v_reg;
    logic [32:0] out_mag_reg;
    logic        out_neg_reg;
    logic [64:0] fin_prod;
    logic [32:0] fin_mag;

    assign fin_prod = 65'(c_side_reg[hvd_pkg::NSTEP-1].x) * 65'(c_t_reg[hvd_pkg::NSTEP-1]);
    assign fin_mag  = c_side_reg[hvd_pkg::NSTEP-1].pc ? c_t_reg[hvd_pkg::NSTEP-1]
                                                      : fin_prod[64:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= c_v_reg[hvd_pkg::NSTEP-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_mag_reg <= fin_mag;
            out_neg_reg <= c_side_reg[hvd_pkg::NSTEP-1].ng && (fin_mag != '0);
        end
    end

    assign out_valid = out_v_reg;
    assign mag       = out_mag_reg;
    assign neg       = out_neg_reg;

endmodule

// ===== hdl/haversine_distance_top.sv =====
// Haversine great-circle distance, fully pipelined.
// Throughput one transaction per cycle, limited only by the output handshake (a stall
// holds every stage). Reset (rst_n, async, active low) empties the pipeline and sets
// the earth radius to 6371000 m; configuration takes effect on the next edge.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module haversine_distance_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [23:0]  cfg_wdata,  // earth_radius_m
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,    // lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata     // dist_cm[31:0]
);

    localparam int unsigned AW = hvd_pkg::ANG_W;
    localparam int unsigned CW = hvd_pkg::CW;

    // Round-toward-zero arithmetic shift
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                    input int unsigned sh);
        logic [CW-1:0] m;
        m = v[CW-1] ? CW'(-v) : CW'(v);
        m = m >> sh;
        return v[CW-1] ? -$signed(m) : $signed(m);
    endfunction

    logic en;
    logic out_v_reg;

    // Global advance: move whenever the output register is free or being taken
    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    // Radius in centimeters, scaled on write
    logic [30:0] radius_cm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_cm_reg <= hvd_pkg::RADIUS_CM_RESET;
        else if (cfg_wen)
            radius_cm_reg <= 31'(cfg_wdata) * 31'd100;
    end

    // Input stage: angle differences and doubled latitudes in half-units
    logic signed [30:0] lat_a_s;
    logic signed [31:0] lon_a_s;
    logic signed [30:0] lat_b_s;
    logic signed [31:0] lon_b_s;
    logic               t0_v_reg;
    logic signed [AW-1:0] t0_ang_reg [4];

    assign lat_a_s = s_tdata[30:0];
    assign lon_a_s = s_tdata[62:31];
    assign lat_b_s = s_tdata[93:63];
    assign lon_b_s = s_tdata[125:94];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t0_v_reg <= 1'b0;
        else if (en)
            t0_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_ang_reg[0] <= AW'(lat_b_s) - AW'(lat_a_s);
            t0_ang_reg[1] <= AW'(lon_b_s) - AW'(lon_a_s);
            t0_ang_reg[2] <= AW'(lat_a_s) + AW'(lat_a_s);
            t0_ang_reg[3] <= AW'(lat_b_s) + AW'(lat_b_s);
        end
    end

    // Four lanes: sine of dlat/2, sine of dlon/2, cosine of each latitude
    logic [3:0]  lane_v;
    logic [32:0] lane_mag [4];
    logic [3:0]  lane_neg;

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        localparam logic WANT_COS = (l >= 2);

        hvd_sincos u_sincos (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (t0_v_reg),
            .angle     (t0_ang_reg[l]),
            .want_cos  (WANT_COS),
            .out_valid (lane_v[l]),
            .mag       (lane_mag[l]),
            .neg       (lane_neg[l])
        );
    end

    // P1: squares of the sines, product of the cosines
    logic        p1_v_reg;
    logic [32:0] p1_hlat_reg;
    logic [32:0] p1_hlon_reg;
    logic [32:0] p1_prod_reg;
    logic        p1_sd_reg;
    logic [65:0] sq_lat;
    logic [65:0] sq_lon;
    logic [65:0] cc_prod;

    assign sq_lat  = 66'(lane_mag[0]) * 66'(lane_mag[0]);
    assign sq_lon  = 66'(lane_mag[1]) * 66'(lane_mag[1]);
    assign cc_prod = 66'(lane_mag[2]) * 66'(lane_mag[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_v_reg <= 1'b0;
        else if (en)
            p1_v_reg <= lane_v[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_hlat_reg <= sq_lat[64:32];
            p1_hlon_reg <= sq_lon[64:32];
            p1_prod_reg <= cc_prod[64:32];
            p1_sd_reg   <= lane_neg[2] ^ lane_neg[3];
        end
    end

    // P2: cosine product times longitude term
    logic        p2_v_reg;
    logic [32:0] p2_hlat_reg;
    logic [32:0] p2_term_reg;
    logic        p2_sd_reg;
    logic [65:0] term_prod;

    assign term_prod = 66'(p1_prod_reg) * 66'(p1_hlon_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_v_reg <= 1'b0;
        else if (en)
            p2_v_reg <= p1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_hlat_reg <= p1_hlat_reg;
            p2_term_reg <= term_prod[64:32];
            p2_sd_reg   <= p1_sd_reg;
        end
    end

    // P3: haversine term, clamped to [0, 1]
    logic              p3_v_reg;
    logic [32:0]       p3_a_reg;
    logic signed [34:0] a_sum;
    logic [32:0]       a_clamp;

    assign a_sum = p2_sd_reg ? $signed(35'(p2_hlat_reg)) - $signed(35'(p2_term_reg))
                             : $signed(35'(p2_hlat_reg)) + $signed(35'(p2_term_reg));

    always_comb
    begin
        priority if (a_sum < 0)
            a_clamp = '0;
        else if (a_sum > $signed(35'(hvd_pkg::ONE_Q32)))
            a_clamp = hvd_pkg::ONE_Q32;
        else
            a_clamp = a_sum[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_v_reg <= 1'b0;
        else if (en)
            p3_v_reg <= p2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p3_a_reg <= a_clamp;
    end

    // Square roots of 1-a (x) and a (y), one result bit per stage
    logic        sq_v_reg    [hvd_pkg::SQ_STEPS+1];
    logic [63:0] sqx_rem_reg [hvd_pkg::SQ_STEPS+1];
    logic [63:0] sqx_res_reg [hvd_pkg::SQ_STEPS+1];
    logic [63:0] sqy_rem_reg [hvd_pkg::SQ_STEPS+1];
    logic [63:0] sqy_res_reg [hvd_pkg::SQ_STEPS+1];
    logic        sq_xone_reg [hvd_pkg::SQ_STEPS+1];
    logic        sq_yone_reg [hvd_pkg::SQ_STEPS+1];
    logic [32:0] one_minus_a;

    assign one_minus_a = hvd_pkg::ONE_Q32 - p3_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (en)
            sq_v_reg[0] <= p3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_rem_reg[0] <= {one_minus_a[31:0], 32'd0};
            sqx_res_reg[0] <= '0;
            sq_xone_reg[0] <= one_minus_a[32];
            sqy_rem_reg[0] <= {p3_a_reg[31:0], 32'd0};
            sqy_res_reg[0] <= '0;
            sq_yone_reg[0] <= p3_a_reg[32];
        end
    end

    for (genvar j = 0; j < hvd_pkg::SQ_STEPS; j++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);

        logic [63:0] x_trial;
        logic [63:0] y_trial;
        logic        x_ge;
        logic        y_ge;

        assign x_trial = sqx_res_reg[j] + BIT;
        assign y_trial = sqy_res_reg[j] + BIT;
        assign x_ge    = sqx_rem_reg[j] >= x_trial;
        assign y_ge    = sqy_rem_reg[j] >= y_trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[j+1] <= 1'b0;
            else if (en)
                sq_v_reg[j+1] <= sq_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sqx_rem_reg[j+1] <= x_ge ? sqx_rem_reg[j] - x_trial : sqx_rem_reg[j];
                sqx_res_reg[j+1] <= x_ge ? (sqx_res_reg[j] >> 1) + BIT : sqx_res_reg[j] >> 1;
                sqy_rem_reg[j+1] <= y_ge ? sqy_rem_reg[j] - y_trial : sqy_rem_reg[j];
                sqy_res_reg[j+1] <= y_ge ? (sqy_res_reg[j] >> 1) + BIT : sqy_res_reg[j] >> 1;
                sq_xone_reg[j+1] <= sq_xone_reg[j];
                sq_yone_reg[j+1] <= sq_yone_reg[j];
            end
        end
    end

    // CORDIC vectoring: atan2(y, x), one rotation per stage
    logic                 cd_v_reg [hvd_pkg::CD_STEPS+1];
    logic signed [CW-1:0] cd_x_reg [hvd_pkg::CD_STEPS+1];
    logic signed [CW-1:0] cd_y_reg [hvd_pkg::CD_STEPS+1];
    logic signed [CW-1:0] cd_z_reg [hvd_pkg::CD_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cd_v_reg[0] <= 1'b0;
        else if (en)
            cd_v_reg[0] <= sq_v_reg[hvd_pkg::SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_x_reg[0] <= sq_xone_reg[hvd_pkg::SQ_STEPS] ? CW'(hvd_pkg::ONE_Q32)
                         : CW'(sqx_res_reg[hvd_pkg::SQ_STEPS][32:0]);
            cd_y_reg[0] <= sq_yone_reg[hvd_pkg::SQ_STEPS] ? CW'(hvd_pkg::ONE_Q32)
                         : CW'(sqy_res_reg[hvd_pkg::SQ_STEPS][32:0]);
            cd_z_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < hvd_pkg::CD_STEPS; j++)
    begin : g_cordic
        localparam logic [31:0] AT = hvd_pkg::atan_q32(j);

        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at_s;

        assign dx   = shr_tz(cd_y_reg[j], j);
        assign dy   = shr_tz(cd_x_reg[j], j);
        assign at_s = $signed(CW'(AT));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cd_v_reg[j+1] <= 1'b0;
            else if (en)
                cd_v_reg[j+1] <= cd_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cd_y_reg[j][CW-1])
                begin
                    cd_x_reg[j+1] <= cd_x_reg[j] + dx;
                    cd_y_reg[j+1] <= cd_y_reg[j] - dy;
                    cd_z_reg[j+1] <= cd_z_reg[j] + at_s;
                end
                else
                begin
                    cd_x_reg[j+1] <= cd_x_reg[j] - dx;
                    cd_y_reg[j+1] <= cd_y_reg[j] + dy;
                    cd_z_reg[j+1] <= cd_z_reg[j] - at_s;
                end
            end
        end
    end

    // D1: central angle (2z, negative taken as 0) times radius
    logic        d1_v_reg;
    logic [32:0] d1_prod_reg;
    logic [33:0] ang;
    logic [64:0] dist_prod;

    assign ang = cd_z_reg[hvd_pkg::CD_STEPS][CW-1] ? '0
               : {cd_z_reg[hvd_pkg::CD_STEPS][32:0], 1'b0};
    assign dist_prod = 65'(radius_cm_reg) * 65'(ang);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d1_v_reg <= 1'b0;
        else if (en)
            d1_v_reg <= cd_v_reg[hvd_pkg::CD_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d1_prod_reg <= dist_prod[64:32];
    end

    // Output register with saturation
    logic [31:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= d1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= d1_prod_reg[32] ? '1 : d1_prod_reg[31:0];
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    `HVD_ASSERT_IMP(a_lanes_in_step, clk, rst_n, 1'b1, ($countones(lane_v) == 0) || ($countones(lane_v) == 4), "sine/cosine lanes out of step")
    `HVD_ASSERT_IMP(a_hav_clamped, clk, rst_n, p3_v_reg, p3_a_reg <= hvd_pkg::ONE_Q32, "haversine term above one")
    `HVD_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, m_tvalid && !m_tready, !s_tready, "input taken during output stall")

endmodule
